[rtl/core/vertex_transform_persp_divide_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the vertex transform block
// Shared concurrent assertion wrappers on a clock, one of them disabled in reset.
// ----------------------------------------------------------------------------
`ifndef VERTEX_TRANSFORM_PERSP_DIVIDE_MACROS_SVH
`define VERTEX_TRANSFORM_PERSP_DIVIDE_MACROS_SVH

// Checked only outside reset.
`define VTPD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define VTPD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/vtpd_pkg.sv]
// ----------------------------------------------------------------------------
// vtpd_pkg
// Types, constants and single-precision helpers for the vertex transform.
// ----------------------------------------------------------------------------
package vtpd_pkg;

  localparam logic [31:0] FP_ONE  = 32'h3F80_0000;
  localparam logic [31:0] FP_QNAN = 32'h7FC0_0000;

  localparam int MUL_LAT  = 2;
  localparam int ADD_LAT  = 2;
  localparam int RCP_ITER = 28;
  localparam int RCP_LAT  = RCP_ITER + 2;

  localparam int NUM_MAT_REGS = 8;

  typedef logic [NUM_MAT_REGS-1:0][63:0] mat_regs_t;

  localparam mat_regs_t MAT_RESET = {
    64'h3F80_0000_0000_0000, 64'h0,
    64'h0000_0000_3F80_0000, 64'h0,
    64'h0,                   64'h3F80_0000_0000_0000,
    64'h0,                   64'h0000_0000_3F80_0000
  };

  typedef struct packed {
    logic       sgn;
    logic [7:0] ex;
    logic [23:0] man;
    logic       nan;
    logic       inf;
    logic       zero;
  } fp_unp_t;

  typedef struct packed {
    logic [24:0]        rem;
    logic [23:0]        dvs;
    logic [RCP_ITER-1:0] quo;
    logic signed [10:0] ex;
    logic               sgn;
    logic               nan;
    logic               winf;
    logic               wzero;
  } rcp_stage_t;

  function automatic fp_unp_t fp_unpack(input logic [31:0] f);
    fp_unp_t u;
    u.sgn  = f[31];
    u.ex   = (f[30:23] == 8'd0) ? 8'd1 : f[30:23];
    u.man  = {(f[30:23] != 8'd0), f[22:0]};
    u.nan  = (f[30:23] == 8'hFF) && (f[22:0] != 23'd0);
    u.inf  = (f[30:23] == 8'hFF) && (f[22:0] == 23'd0);
    u.zero = (f[30:0] == 31'd0);
    return u;
  endfunction

  function automatic logic [5:0] lzc48(input logic [47:0] m);
    logic [5:0] lz;
    logic       found;
    lz    = 6'd48;
    found = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!found && m[i]) begin
        lz    = 6'(47 - i);
        found = 1'b1;
      end
    end
    return lz;
  endfunction

  function automatic logic [4:0] lzc24(input logic [23:0] m);
    logic [4:0] lz;
    logic       found;
    lz    = 5'd24;
    found = 1'b0;
    for (int i = 23; i >= 0; i--) begin
      if (!found && m[i]) begin
        lz    = 5'(23 - i);
        found = 1'b1;
      end
    end
    return lz;
  endfunction

  // Rounds sign * m / 2^46 * 2^(e-127) to nearest even, subnormals kept.
  function automatic logic [31:0] round_pack(input logic sgn, input logic [47:0] m,
                                             input logic signed [10:0] e);
    logic [5:0]         lz;
    logic [47:0]        mn;
    logic signed [11:0] ee;
    logic signed [11:0] shw;
    logic [5:0]         sh;
    logic [95:0]        wide;
    logic [7:0]         ex;
    logic [22:0]        frac;
    logic               g;
    logic               s;
    logic               inc;
    logic [31:0]        res;
    lz   = lzc48(m);
    mn   = m << lz;
    ee   = e + 12'sd1 - $signed({6'b0, lz});
    shw  = 12'sd1 - ee;
    sh   = (shw > 12'sd48) ? 6'd48 : shw[5:0];
    wide = {mn, 48'b0} >> sh;
    if (ee >= 12'sd1) begin
      ex   = ee[7:0];
      frac = mn[46:24];
      g    = mn[23];
      s    = |mn[22:0];
    end else begin
      ex   = 8'd0;
      frac = wide[94:72];
      g    = wide[71];
      s    = |wide[70:0];
    end
    inc = g & (s | frac[0]);
    res = {sgn, ex, frac} + {31'b0, inc};
    if (m == 48'd0) begin
      res = {sgn, 31'b0};
    end else if (ee >= 12'sd255) begin
      res = {sgn, 8'hFF, 23'b0};
    end
    return res;
  endfunction

endpackage

[rtl/core/vtpd_in_if.sv]
// ----------------------------------------------------------------------------
// vtpd_in_if
// Vertex request channel: valid/ready handshake with the vertex fields.
// ----------------------------------------------------------------------------
interface vtpd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] pos_z;
  logic [31:0] in_base_color;
  logic [31:0] in_offset_color;
  logic [31:0] in_tex_u;
  logic [31:0] in_tex_v;
  logic        in_last;

  modport source(output valid, pos_x, pos_y, pos_z, in_base_color, in_offset_color,
                 in_tex_u, in_tex_v, in_last, input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, in_base_color, in_offset_color,
               in_tex_u, in_tex_v, in_last, output ready);
endinterface

[rtl/core/vtpd_out_if.sv]
// ----------------------------------------------------------------------------
// vtpd_out_if
// Transformed vertex channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
interface vtpd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_x;
  logic [31:0] out_y;
  logic [31:0] out_z;
  logic [31:0] out_base_color;
  logic [31:0] out_offset_color;
  logic [31:0] out_tex_u;
  logic [31:0] out_tex_v;
  logic        out_last;

  modport source(output valid, out_x, out_y, out_z, out_base_color, out_offset_color,
                 out_tex_u, out_tex_v, out_last, input ready);
  modport sink(input valid, out_x, out_y, out_z, out_base_color, out_offset_color,
               out_tex_u, out_tex_v, out_last, output ready);
endinterface

[rtl/core/vtpd_delay.sv]
// ----------------------------------------------------------------------------
// vtpd_delay
// Enabled shift line that keeps side data aligned with the float units.
// ----------------------------------------------------------------------------
module vtpd_delay #(
  parameter int W = 32,
  parameter int D = 2
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);
  logic [W-1:0] sr_r [D];

  always_ff @(posedge clk) begin
    if (en) begin
      sr_r[0] <= din;
      for (int i = 1; i < D; i++) begin
        sr_r[i] <= sr_r[i-1];
      end
    end
  end

  assign dout = sr_r[D-1];
endmodule

[rtl/core/vtpd_fmul.sv]
// ----------------------------------------------------------------------------
// vtpd_fmul
// Two-stage single-precision multiplier: mantissa product, then round.
// ----------------------------------------------------------------------------
module vtpd_fmul (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);
  import vtpd_pkg::*;

  fp_unp_t            ua;
  fp_unp_t            ub;
  logic [47:0]        prod_r;
  logic signed [10:0] ex_r;
  logic               sgn_r;
  logic               nan_r;
  logic               inf_r;
  logic [31:0]        y_r;

  assign ua = fp_unpack(a);
  assign ub = fp_unpack(b);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= {24'b0, ua.man} * {24'b0, ub.man};
      ex_r   <= $signed({3'b0, ua.ex}) + $signed({3'b0, ub.ex}) - 11'sd127;
      sgn_r  <= ua.sgn ^ ub.sgn;
      nan_r  <= ua.nan | ub.nan | (ua.inf & ub.zero) | (ub.inf & ua.zero);
      inf_r  <= ua.inf | ub.inf;
      if (nan_r) begin
        y_r <= FP_QNAN;
      end else if (inf_r) begin
        y_r <= {sgn_r, 8'hFF, 23'b0};
      end else begin
        y_r <= round_pack(sgn_r, prod_r, ex_r);
      end
    end
  end

  assign y = y_r;
endmodule

[rtl/core/vtpd_fadd.sv]
// ----------------------------------------------------------------------------
// vtpd_fadd
// Two-stage single-precision adder: align and add, then normalize and round.
// ----------------------------------------------------------------------------
module vtpd_fadd (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);
  import vtpd_pkg::*;

  fp_unp_t     ua;
  fp_unp_t     ub;
  fp_unp_t     big;
  fp_unp_t     sml;
  logic        a_big;
  logic [7:0]  d;
  logic [5:0]  dcap;
  logic [47:0] mbw;
  logic [95:0] wide;
  logic [47:0] smw;
  logic        sub;
  logic [47:0] sum;

  logic [47:0]        sum_r;
  logic signed [10:0] ex_r;
  logic               sgn_r;
  logic               nan_r;
  logic               inf_r;
  logic               isg_r;
  logic [31:0]        y_r;

  assign ua    = fp_unpack(a);
  assign ub    = fp_unpack(b);
  assign a_big = (a[30:0] >= b[30:0]);
  assign big   = a_big ? ua : ub;
  assign sml   = a_big ? ub : ua;
  assign d     = big.ex - sml.ex;
  assign dcap  = (d > 8'd48) ? 6'd48 : d[5:0];
  assign mbw   = {1'b0, big.man, 23'b0};
  assign wide  = {1'b0, sml.man, 23'b0, 48'b0} >> dcap;
  // Bits shifted out of the smaller operand collapse into one sticky bit.
  assign smw   = wide[95:48] | {47'b0, |wide[47:0]};
  assign sub   = ua.sgn ^ ub.sgn;
  assign sum   = sub ? (mbw - smw) : (mbw + smw);

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= sum;
      ex_r  <= $signed({3'b0, big.ex});
      sgn_r <= (sum == 48'd0) ? (ua.sgn & ub.sgn) : big.sgn;
      nan_r <= ua.nan | ub.nan | (ua.inf & ub.inf & sub);
      inf_r <= ua.inf | ub.inf;
      isg_r <= ua.inf ? ua.sgn : ub.sgn;
      if (nan_r) begin
        y_r <= FP_QNAN;
      end else if (inf_r) begin
        y_r <= {isg_r, 8'hFF, 23'b0};
      end else begin
        y_r <= round_pack(sgn_r, sum_r, ex_r);
      end
    end
  end

  assign y = y_r;
endmodule

[rtl/core/vtpd_recip.sv]
// ----------------------------------------------------------------------------
// vtpd_recip
// Pipelined reciprocal: unpack, one restoring quotient bit per stage, round.
// ----------------------------------------------------------------------------
module vtpd_recip (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] w,
  output logic [31:0] y
);
  import vtpd_pkg::*;

  fp_unp_t            uw;
  logic [4:0]         lz;
  logic signed [10:0] ewn;
  rcp_stage_t         st0;
  rcp_stage_t         st_r [RCP_ITER+1];
  rcp_stage_t         fin;
  logic               sticky;
  logic [31:0]        y_r;

  assign uw  = fp_unpack(w);
  assign lz  = lzc24(uw.man);
  assign ewn = $signed({3'b0, uw.ex}) - $signed({6'b0, lz});

  always_comb begin
    st0.rem   = 25'h080_0000;
    st0.dvs   = uw.man << lz;
    st0.quo   = '0;
    st0.ex    = 11'sd253 - ewn;
    st0.sgn   = uw.sgn;
    st0.nan   = uw.nan;
    st0.winf  = uw.inf;
    st0.wzero = uw.zero;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= st0;
    end
  end

  for (genvar k = 0; k < RCP_ITER; k++) begin : g_step
    logic        ge;
    logic [24:0] diff;
    rcp_stage_t  nx;

    assign ge   = (st_r[k].rem >= {1'b0, st_r[k].dvs});
    assign diff = ge ? (st_r[k].rem - {1'b0, st_r[k].dvs}) : st_r[k].rem;

    always_comb begin
      nx     = st_r[k];
      nx.rem = {diff[23:0], 1'b0};
      nx.quo = {st_r[k].quo[RCP_ITER-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k+1] <= nx;
      end
    end
  end

  assign fin    = st_r[RCP_ITER];
  assign sticky = (fin.rem != 25'd0);

  always_ff @(posedge clk) begin
    if (en) begin
      if (fin.nan) begin
        y_r <= FP_QNAN;
      end else if (fin.winf) begin
        y_r <= {fin.sgn, 31'b0};
      end else if (fin.wzero) begin
        y_r <= {fin.sgn, 8'hFF, 23'b0};
      end else begin
        y_r <= round_pack(fin.sgn, {fin.quo, sticky, 19'b0}, fin.ex);
      end
    end
  end

  assign y = y_r;
endmodule

[rtl/core/vertex_transform_persp_divide.sv]
// ----------------------------------------------------------------------------
// vertex_transform_persp_divide
// Matrix transform of a vertex position followed by a perspective divide.
// ----------------------------------------------------------------------------
// One vertex request enters on in_vtx and one transformed vertex leaves on
// out_vtx; both are valid/ready channels. The position (x, y, z, 1) is
// multiplied by the column-major matrix written through the cfg_ port; each
// product and each sum is rounded on its own. When w is neither 1.0 nor a
// signed zero, x, y and z are multiplied by the rounded reciprocal of w.
// The color and texture words and the last marker travel alongside unchanged.
// The path runs through the column products, the three chained adds, the
// reciprocal of w (one quotient bit per stage) and the final multiply. It
// takes one vertex per cycle while the receiver does not stall a result.
// Reset clears all valid bits and loads the identity matrix.
// When the receiver stalls with a result waiting, the whole pipeline holds,
// so in_vtx.ready follows out_vtx.ready while a result is pending.
// The matrix may only be rewritten while no vertex is in flight.
// ----------------------------------------------------------------------------
module vertex_transform_persp_divide (
  input  logic        clk,
  input  logic        rst_n,
  vtpd_in_if.sink     in_vtx,
  vtpd_out_if.source  out_vtx,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [63:0] cfg_data
);
  import vtpd_pkg::*;

  localparam int ACC_LAT  = MUL_LAT + 3 * ADD_LAT;
  localparam int PIPE_LAT = ACC_LAT + RCP_LAT + MUL_LAT;

  // Matrix registers; the low word of each is the even row.
  mat_regs_t   mat_r;
  logic [31:0] mat [4][4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r <= MAT_RESET;
    end else if (cfg_we) begin
      mat_r[cfg_idx] <= cfg_data;
    end
  end

  for (genvar c = 0; c < 4; c++) begin : g_mcol
    for (genvar r = 0; r < 4; r++) begin : g_mrow
      assign mat[c][r] = r[0] ? mat_r[2*c + r/2][63:32] : mat_r[2*c + r/2][31:0];
    end
  end

  // The whole pipeline advances together unless the finished result is stalled.
  logic                en;
  logic [PIPE_LAT-1:0] vld_r;

  assign en           = !vld_r[PIPE_LAT-1] || out_vtx.ready;
  assign in_vtx.ready = en;
  assign out_vtx.valid = vld_r[PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_LAT-2:0], in_vtx.valid};
    end
  end

  // Column products for x, y and z. Column 3 is scaled by 1.0, which leaves
  // its entries exact, so they go straight to the last add.
  logic [31:0] pos [3];
  logic [31:0] prod [3][4];
  logic [31:0] sum1 [4];
  logic [31:0] sum2 [4];
  logic [31:0] acc [4];
  logic [127:0] p2_flat;
  logic [127:0] p2_dly;

  assign pos[0] = in_vtx.pos_x;
  assign pos[1] = in_vtx.pos_y;
  assign pos[2] = in_vtx.pos_z;

  for (genvar c = 0; c < 3; c++) begin : g_pcol
    for (genvar r = 0; r < 4; r++) begin : g_prow
      vtpd_fmul u_mul (
        .clk (clk),
        .en  (en),
        .a   (mat[c][r]),
        .b   (pos[c]),
        .y   (prod[c][r])
      );
    end
  end

  // The column 2 product waits for the first sum.
  for (genvar r = 0; r < 4; r++) begin : g_p2
    assign p2_flat[32*r +: 32] = prod[2][r];
  end

  vtpd_delay #(.W(128), .D(ADD_LAT)) u_p2_dly (
    .clk  (clk),
    .en   (en),
    .din  (p2_flat),
    .dout (p2_dly)
  );

  for (genvar r = 0; r < 4; r++) begin : g_sum
    vtpd_fadd u_add1 (
      .clk (clk),
      .en  (en),
      .a   (prod[0][r]),
      .b   (prod[1][r]),
      .y   (sum1[r])
    );
    vtpd_fadd u_add2 (
      .clk (clk),
      .en  (en),
      .a   (sum1[r]),
      .b   (p2_dly[32*r +: 32]),
      .y   (sum2[r])
    );
    vtpd_fadd u_add3 (
      .clk (clk),
      .en  (en),
      .a   (sum2[r]),
      .b   (mat[3][r]),
      .y   (acc[r])
    );
  end

  // Reciprocal of w, with x, y, z and w held back to meet it.
  logic [31:0]  inv_w;
  logic [127:0] acc_flat;
  logic [127:0] acc_dly;
  logic [31:0]  w_dly;
  logic         div_en;

  assign acc_flat = {acc[3], acc[2], acc[1], acc[0]};

  vtpd_recip u_rcp (
    .clk (clk),
    .en  (en),
    .w   (acc[3]),
    .y   (inv_w)
  );

  vtpd_delay #(.W(128), .D(RCP_LAT)) u_acc_dly (
    .clk  (clk),
    .en   (en),
    .din  (acc_flat),
    .dout (acc_dly)
  );

  assign w_dly  = acc_dly[127:96];
  // A NaN w is not equal to 1.0 or zero, so it takes the divide path.
  assign div_en = (w_dly != FP_ONE) && (w_dly[30:0] != 31'd0);

  logic [31:0] quot [3];
  logic [96:0] fin_dly;
  logic [31:0] res [3];

  for (genvar r = 0; r < 3; r++) begin : g_div
    vtpd_fmul u_mul (
      .clk (clk),
      .en  (en),
      .a   (acc_dly[32*r +: 32]),
      .b   (inv_w),
      .y   (quot[r])
    );
  end

  vtpd_delay #(.W(97), .D(MUL_LAT)) u_fin_dly (
    .clk  (clk),
    .en   (en),
    .din  ({div_en, acc_dly[95:0]}),
    .dout (fin_dly)
  );

  // Every NaN in x, y and z leaves as the canonical quiet NaN.
  for (genvar r = 0; r < 3; r++) begin : g_res
    logic [31:0] pick;
    assign pick   = fin_dly[96] ? quot[r] : fin_dly[32*r +: 32];
    assign res[r] = (pick[30:0] > 31'h7F80_0000) ? FP_QNAN : pick;
  end

  assign out_vtx.out_x = res[0];
  assign out_vtx.out_y = res[1];
  assign out_vtx.out_z = res[2];

  // Attribute words ride a shift line as deep as the whole pipeline.
  logic [128:0] attr_dly;

  vtpd_delay #(.W(129), .D(PIPE_LAT)) u_attr_dly (
    .clk  (clk),
    .en   (en),
    .din  ({in_vtx.in_last, in_vtx.in_tex_v, in_vtx.in_tex_u,
            in_vtx.in_offset_color, in_vtx.in_base_color}),
    .dout (attr_dly)
  );

  assign out_vtx.out_base_color   = attr_dly[31:0];
  assign out_vtx.out_offset_color = attr_dly[63:32];
  assign out_vtx.out_tex_u        = attr_dly[95:64];
  assign out_vtx.out_tex_v        = attr_dly[127:96];
  assign out_vtx.out_last         = attr_dly[128];
endmodule

[rtl/core/vtpd_checker.sv]
// ----------------------------------------------------------------------------
// vtpd_checker
// Port-level checks of the vertex transform handshakes, bound to the top.
// ----------------------------------------------------------------------------
`include "vertex_transform_persp_divide_macros.svh"

module vtpd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_x
);
  // A stalled result stays offered.
  `VTPD_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped")

  // A stalled result keeps its position word.
  `VTPD_ASSERT(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(out_x), "result changed")

  // With no result waiting the pipeline must take requests.
  `VTPD_ASSERT(a_in_free, clk, rst_n, !out_valid |-> in_ready, "input blocked")

  // Reset empties the pipeline.
  `VTPD_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> !out_valid, "valid after reset")
endmodule

bind vertex_transform_persp_divide vtpd_checker u_vtpd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_vtx.ready),
  .out_valid (out_vtx.valid),
  .out_ready (out_vtx.ready),
  .out_x     (out_vtx.out_x)
);

[tb/sv/vertex_transform_persp_divide_tb.sv]
// ----------------------------------------------------------------------------
// Vertex transform testbench
// Streams vertex requests through the block under several matrix settings.
// A scoreboard predicts each transformed vertex in single precision and
// checks the results field by field, in order.
// ----------------------------------------------------------------------------
module vertex_transform_persp_divide_tb;
  import vtpd_pkg::*;

  localparam int  LATENCY     = 40;
  localparam int  SETTLE      = LATENCY + 8;
  localparam int  CYCLE_LIMIT = 400000;
  localparam int  IDLE_PCT    = 38;

  localparam logic [31:0] FP_NEG_ONE = 32'hBF80_0000;
  localparam logic [31:0] FP_MAX     = 32'h7F7F_FFFF;
  localparam logic [31:0] FP_INF     = 32'h7F80_0000;
  localparam logic [31:0] FP_NEG_INF = 32'hFF80_0000;
  localparam logic [31:0] FP_MIN_SUB = 32'h0000_0001;

  // Register indexes, in the order of the matrix register file.
  typedef enum logic [2:0] {
    REG_COL0_XY, REG_COL0_ZW, REG_COL1_XY, REG_COL1_ZW,
    REG_COL2_XY, REG_COL2_ZW, REG_COL3_XY, REG_COL3_ZW
  } mat_reg_e;

  typedef struct {
    logic [31:0] x, y, z;
    logic [31:0] base_color, offset_color, tex_u, tex_v;
    logic        last;
  } vertex_t;

  // Holds the expected transformed vertices and its own copy of the matrix.
  class vertex_scoreboard;
    logic [63:0] matrix [NUM_MAT_REGS];
    vertex_t     expected_q [$];
    int          errors;

    function new();
      matrix = '{64'h0000_0000_3F80_0000, 64'h0, 64'h3F80_0000_0000_0000, 64'h0,
                 64'h0, 64'h0000_0000_3F80_0000, 64'h0, 64'h3F80_0000_0000_0000};
      errors = 0;
    endfunction

    function void set_reg(mat_reg_e idx, logic [63:0] value);
      matrix[idx] = value;
    endfunction

    // Widens single bits to a double; every single value is exact there.
    static function real widen(logic [31:0] f);
      real r;
      if (f[30:23] == 8'hFF)
        return $bitstoreal({f[31], 11'h7FF, f[22:0], 29'b0});
      if (f[30:0] == 31'd0)
        return $bitstoreal({f[31], 63'b0});
      if (f[30:23] == 8'd0) begin
        r = real'(f[22:0]) * $bitstoreal(64'h36A0_0000_0000_0000);
        return f[31] ? -r : r;
      end
      return $bitstoreal({f[31], 11'(f[30:23] - 8'd127 + 11'd1023), f[22:0], 29'b0});
    endfunction

    // Rounds a double to single, nearest even, subnormals kept. Products,
    // sums and quotients of singles computed in double and rounded once more
    // here give the correctly rounded single result.
    static function logic [31:0] narrow(real r);
      logic [63:0] d;
      logic [63:0] sig;
      logic [63:0] kept;
      int          e;
      int          sh;
      logic        g, st;
      logic [31:0] base;
      d = $realtobits(r);
      if (d[62:52] == 11'h7FF)
        return (d[51:0] != 0) ? FP_QNAN : {d[63], 8'hFF, 23'b0};
      if (d[62:52] == 11'd0)
        return {d[63], 31'b0};
      e = int'(d[62:52]) - 1023;
      if (e > 127)
        return {d[63], 8'hFF, 23'b0};
      sig  = {11'b0, 1'b1, d[51:0]};
      sh   = (e >= -126) ? 29 : 29 + (-126 - e);
      if (sh > 60)
        sh = 60;
      kept = sig >> sh;
      g    = sig[sh-1];
      st   = (sig & ((64'd1 << (sh - 1)) - 64'd1)) != 0;
      base = (e >= -126) ? {d[63], 8'(e + 127), kept[22:0]} : {d[63], 8'd0, kept[22:0]};
      return base + {31'b0, g & (st | kept[0])};
    endfunction

    function logic [31:0] entry(int col, int row);
      logic [63:0] r;
      r = matrix[col * 2 + row / 2];
      return (row % 2) ? r[63:32] : r[31:0];
    endfunction

    function vertex_t transform(vertex_t v);
      logic [31:0] pos [4];
      logic [31:0] acc [4];
      logic [31:0] recip;
      vertex_t     res;
      pos = '{v.x, v.y, v.z, FP_ONE};
      for (int row = 0; row < 4; row++)
        acc[row] = narrow(widen(entry(0, row)) * widen(pos[0]));
      for (int col = 1; col < 4; col++)
        for (int row = 0; row < 4; row++)
          acc[row] = narrow(widen(acc[row]) +
                            widen(narrow(widen(entry(col, row)) * widen(pos[col]))));
      // The divide is skipped only for w of exactly one or a signed zero;
      // a NaN w divides.
      if (acc[3] != FP_ONE && acc[3][30:0] != 31'd0) begin
        recip = narrow(1.0 / widen(acc[3]));
        for (int row = 0; row < 3; row++)
          acc[row] = narrow(widen(acc[row]) * widen(recip));
      end
      res = v;
      res.x = acc[0];
      res.y = acc[1];
      res.z = acc[2];
      return res;
    endfunction

    function void note_request(vertex_t v);
      expected_q.push_back(transform(v));
    endfunction

    task report(string field, logic [31:0] got, logic [31:0] want);
      $display("mismatch on %s: got %h, expected %h", field, got, want);
      errors++;
    endtask

    task check_result(vertex_t r);
      vertex_t w;
      if (expected_q.size() == 0) begin
        report("out_x of a result with no request outstanding", r.x, 32'bx);
        return;
      end
      w = expected_q.pop_front();
      if (r.x !== w.x) report("out_x", r.x, w.x);
      if (r.y !== w.y) report("out_y", r.y, w.y);
      if (r.z !== w.z) report("out_z", r.z, w.z);
      if (r.base_color !== w.base_color)
        report("out_base_color", r.base_color, w.base_color);
      if (r.offset_color !== w.offset_color)
        report("out_offset_color", r.offset_color, w.offset_color);
      if (r.tex_u !== w.tex_u) report("out_tex_u", r.tex_u, w.tex_u);
      if (r.tex_v !== w.tex_v) report("out_tex_v", r.tex_v, w.tex_v);
      if (r.last !== w.last) report("out_last", {31'b0, r.last}, {31'b0, w.last});
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [63:0] cfg_data;
  int          cycle;
  bit          steady;      // when set, neither side idles
  vertex_t     send_q [$];  // requests waiting to be offered
  vertex_t     cur;
  vertex_t     got;

  vertex_scoreboard sb;

  vtpd_in_if  in_vtx ();
  vtpd_out_if out_vtx ();

  vertex_transform_persp_divide u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vtx   (in_vtx),
    .out_vtx  (out_vtx),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Everything the block sees starts known, before the first edge.
  initial begin
    sb                     = new();
    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_idx                = 3'd0;
    cfg_data               = 64'd0;
    steady                 = 1'b0;
    in_vtx.valid           = 1'b0;
    in_vtx.pos_x           = 32'd0;
    in_vtx.pos_y           = 32'd0;
    in_vtx.pos_z           = 32'd0;
    in_vtx.in_base_color   = 32'd0;
    in_vtx.in_offset_color = 32'd0;
    in_vtx.in_tex_u        = 32'd0;
    in_vtx.in_tex_v        = 32'd0;
    in_vtx.in_last         = 1'b0;
    out_vtx.ready          = 1'b0;
  end

  // Watchdog: a run that hangs ends here.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end
  initial cycle = 0;

  // Request side. The scoreboard hears of a request when it is accepted;
  // a new request is offered only once the current one has gone, or none
  // was on the bus. Random gaps hold valid low between requests.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_vtx.valid <= 1'b0;
    end else begin
      if (in_vtx.valid && in_vtx.ready) begin
        cur.x            = in_vtx.pos_x;
        cur.y            = in_vtx.pos_y;
        cur.z            = in_vtx.pos_z;
        cur.base_color   = in_vtx.in_base_color;
        cur.offset_color = in_vtx.in_offset_color;
        cur.tex_u        = in_vtx.in_tex_u;
        cur.tex_v        = in_vtx.in_tex_v;
        cur.last         = in_vtx.in_last;
        sb.note_request(cur);
      end
      if (!in_vtx.valid || in_vtx.ready) begin
        if (send_q.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          cur = send_q.pop_front();
          in_vtx.valid           <= 1'b1;
          in_vtx.pos_x           <= cur.x;
          in_vtx.pos_y           <= cur.y;
          in_vtx.pos_z           <= cur.z;
          in_vtx.in_base_color   <= cur.base_color;
          in_vtx.in_offset_color <= cur.offset_color;
          in_vtx.in_tex_u        <= cur.tex_u;
          in_vtx.in_tex_v        <= cur.tex_v;
          in_vtx.in_last         <= cur.last;
        end else begin
          in_vtx.valid <= 1'b0;
        end
      end
    end
  end

  // Result side: checks each accepted result and stalls at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_vtx.ready <= 1'b0;
    end else begin
      if (out_vtx.valid && out_vtx.ready) begin
        got.x            = out_vtx.out_x;
        got.y            = out_vtx.out_y;
        got.z            = out_vtx.out_z;
        got.base_color   = out_vtx.out_base_color;
        got.offset_color = out_vtx.out_offset_color;
        got.tex_u        = out_vtx.out_tex_u;
        got.tex_v        = out_vtx.out_tex_v;
        got.last         = out_vtx.out_last;
        sb.check_result(got);
      end
      out_vtx.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Writes one matrix register; the scoreboard copy follows at once, which
  // is safe because writes happen only with the pipeline empty.
  task automatic write_reg(mat_reg_e idx, logic [63:0] value);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    sb.set_reg(idx, value);
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic load_matrix(logic [63:0] m [NUM_MAT_REGS]);
    for (int i = 0; i < NUM_MAT_REGS; i++)
      write_reg(mat_reg_e'(i), m[i]);
  endtask

  // Waits until every request has been sent and every result has come back,
  // then lets the pipeline settle before the matrix may change.
  task automatic drain();
    do @(negedge clk);
    while (send_q.size() != 0 || in_vtx.valid || sb.expected_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Modest magnitudes half of the time so that the arithmetic stays meaningful,
  // with specials, subnormals, huge values and raw bit patterns mixed in.
  function automatic logic [31:0] rand_float();
    logic [31:0] specials [10];
    specials = '{32'h0, 32'h8000_0000, FP_ONE, FP_NEG_ONE, FP_INF, FP_NEG_INF,
                 FP_QNAN, 32'hFF80_0001, FP_MAX, FP_MIN_SUB};
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return {1'($urandom), 8'($urandom_range(112, 140)), 23'($urandom)};
      5:             return specials[$urandom_range(0, 9)];
      6:             return {1'($urandom), 8'd0, 23'($urandom)};
      7:             return {1'($urandom), 8'($urandom_range(236, 254)), 23'($urandom)};
      default:       return $urandom;
    endcase
  endfunction

  task automatic queue_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    vertex_t v;
    v.x            = x;
    v.y            = y;
    v.z            = z;
    v.base_color   = $urandom;
    v.offset_color = $urandom;
    v.tex_u        = $urandom;
    v.tex_v        = $urandom;
    v.last         = 1'($urandom);
    send_q.push_back(v);
  endtask

  task automatic queue_random(int count);
    for (int i = 0; i < count; i++)
      queue_vertex(rand_float(), rand_float(), rand_float());
  endtask

  function automatic logic [31:0] modest();
    return {1'($urandom), 8'($urandom_range(118, 132)), 23'($urandom)};
  endfunction

  initial begin
    logic [63:0] m [NUM_MAT_REGS];
    vertex_t     v;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Identity matrix from reset: w stays one for finite positions, so no
    // divide. Extremes of the position fields run through the products and sums.
    queue_vertex(32'h0, 32'h8000_0000, FP_ONE);
    queue_vertex(FP_MAX, 32'hFF7F_FFFF, FP_MIN_SUB);
    queue_vertex(32'h807F_FFFF, FP_INF, FP_NEG_INF);
    queue_vertex(32'h7FC0_0001, 32'hFFFF_FFFF, 32'h7F80_0001);
    v = '{x: 32'hFFFF_FFFF, y: 32'hFFFF_FFFF, z: 32'hFFFF_FFFF, base_color: 32'hFFFF_FFFF,
          offset_color: 32'hFFFF_FFFF, tex_u: 32'hFFFF_FFFF, tex_v: 32'hFFFF_FFFF,
          last: 1'b1};
    send_q.push_back(v);
    v = '{x: 32'h0, y: 32'h0, z: 32'h0, base_color: 32'h0, offset_color: 32'h0,
          tex_u: 32'h0, tex_v: 32'h0, last: 1'b0};
    send_q.push_back(v);
    queue_random(80);
    drain();

    // Perspective projection: w = -z and x, y, z are translated, so w of one,
    // zero, infinity and NaN all come from z, along with the ordinary divide.
    m = '{{32'h0, 32'h3FC0_0000}, 64'h0, {32'h3FA0_0000, 32'h0}, 64'h0,
          {32'h3E80_0000, 32'hBE00_0000}, {FP_NEG_ONE, 32'hBF83_0000},
          {32'h4000_0000, 32'hC040_0000}, {32'h0, 32'hC100_0000}};
    load_matrix(m);
    queue_vertex(FP_ONE, FP_ONE, FP_NEG_ONE);   // w of exactly one
    queue_vertex(FP_ONE, FP_NEG_ONE, 32'h0);    // w of plus zero
    queue_vertex(FP_ONE, FP_ONE, 32'h8000_0000);
    queue_vertex(32'h4000_0000, FP_ONE, FP_INF);     // infinite w
    queue_vertex(32'h4000_0000, FP_ONE, FP_NEG_INF);
    queue_vertex(FP_ONE, FP_ONE, FP_QNAN);           // NaN w still divides
    queue_vertex(FP_ONE, FP_ONE, FP_MIN_SUB);
    queue_vertex(FP_ONE, FP_ONE, FP_MAX);
    steady = 1'b1;
    for (int i = 0; i < 90; i++)
      queue_vertex(modest(), modest(), modest());
    drain();
    steady = 1'b0;
    queue_random(40);
    drain();

    // A random matrix of modest entries, including a random w row.
    for (int i = 0; i < NUM_MAT_REGS; i++)
      m[i] = {modest(), modest()};
    load_matrix(m);
    for (int i = 0; i < 70; i++)
      queue_vertex(modest(), modest(), modest());
    queue_random(30);
    drain();

    // Extremes: largest finite entries overflow, tiny ones go subnormal, two are infinite.
    m = '{{FP_MAX, FP_MAX}, {32'hFF7F_FFFF, FP_MIN_SUB}, {FP_MIN_SUB, 32'h807F_FFFF},
          {FP_MAX, 32'h0}, {32'h0080_0000, FP_MAX}, {FP_NEG_ONE, 32'h8000_0001},
          {FP_INF, 32'h0}, {32'h0, FP_NEG_INF}};
    load_matrix(m);
    queue_random(40);
    drain();

    // Every register all ones, then all zeros.
    for (int i = 0; i < NUM_MAT_REGS; i++)
      m[i] = 64'hFFFF_FFFF_FFFF_FFFF;
    load_matrix(m);
    queue_random(15);
    drain();
    for (int i = 0; i < NUM_MAT_REGS; i++)
      m[i] = 64'h0;
    load_matrix(m);
    queue_random(15);
    drain();

    // Raw random register bits.
    for (int i = 0; i < NUM_MAT_REGS; i++)
      m[i] = {$urandom, $urandom};
    load_matrix(m);
    queue_random(40);
    drain();

    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
